// File: hdl/dafs_pkg.sv
// Shared types and constants for the decaying anchor force sum block.
package dafs_pkg;

    localparam int COORD_W   = 32;
    localparam int WEIGHT_W  = 24;
    localparam int DECAY_W   = 17;
    localparam int COUNT_W   = 5;
    localparam int IDX_W     = 4;
    localparam int MAG_W     = 31;
    localparam int ROOT_W    = 32;
    localparam int SQ_W      = 64;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 24;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 24'd6;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [IDX_W-1:0]           entry_index;
        logic signed [COORD_W-1:0]  target_x;
        logic signed [COORD_W-1:0]  target_y;
        logic [WEIGHT_W-1:0]        start_weight;
        logic [DECAY_W-1:0]         decay_factor;
        logic signed [COORD_W-1:0]  birth_iter;
        logic signed [COORD_W-1:0]  lifetime;
        logic                       target_present;
        logic signed [COORD_W-1:0]  agent_x;
        logic signed [COORD_W-1:0]  agent_y;
        logic signed [COORD_W-1:0]  now_iter;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  net_x;
        logic signed [COORD_W-1:0]  net_y;
        logic                       was_query;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] active_count;
    } t_cfg_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_SQRT,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_DECAY,
        ST_DONE
    } t_state;

    // Adds a signed contribution of magnitude mag and clamps to the 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] acc,
        input logic                      neg,
        input logic [WEIGHT_W-1:0]       mag
    );
        logic signed [COORD_W+1:0] ext;
        logic signed [COORD_W+1:0] sum;
        ext = $signed({{(COORD_W+2-WEIGHT_W){1'b0}}, mag});
        sum = {{2{acc[COORD_W-1]}}, acc} + (neg ? -ext : ext);
        if (sum > $signed({2'b00, 1'b0, {(COORD_W-1){1'b1}}})) begin
            sat_add = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum < $signed({2'b11, 1'b1, {(COORD_W-1){1'b0}}})) begin
            sat_add = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_add = sum[COORD_W-1:0];
        end
    endfunction

endpackage

// File: hdl/dafs_stream_if.sv
// Valid/ready channel carrying one payload item per request.
interface dafs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/decaying_anchor_force_sum_top.sv
// Decaying anchor force sum: anchor table with one shared multiplier, square root and divider.
// A write request updates the anchor entry and then reports a result. A query visits each active
// anchor in turn: a skipped anchor is only looked up and decayed, and one that contributes also takes
// two squares, the square root and a multiply/divide per axis on the shared unit before its decay.
// One request is processed at a time; a new request is accepted only in the idle state.
// A finished result waits in the output register. Synchronous active-low reset clears control
// state, active_count and the has-target flags.
module decaying_anchor_force_sum_top
    import dafs_pkg::*;
#(
    parameter int MAX_ANCHORS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dafs_stream_if.sink   i_cfg,
    dafs_stream_if.sink   i_in,
    dafs_stream_if.source o_out
);

    localparam int IW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int CW = $clog2(MAX_ANCHORS + 1);

    // Anchor table.
    logic [COORD_W-1:0]  r_tx_mem   [MAX_ANCHORS];
    logic [COORD_W-1:0]  r_ty_mem   [MAX_ANCHORS];
    logic [WEIGHT_W-1:0] r_w_mem    [MAX_ANCHORS];
    logic [DECAY_W-1:0]  r_dec_mem  [MAX_ANCHORS];
    logic [COORD_W-1:0]  r_birth_mem[MAX_ANCHORS];
    logic [COORD_W-1:0]  r_life_mem [MAX_ANCHORS];
    logic                r_has_mem  [MAX_ANCHORS];

    t_state r_state, n_state;
    logic [COUNT_W-1:0]        r_active, n_active;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [CW-1:0]             r_i, n_i;
    logic signed [COORD_W-1:0] r_ax, n_ax, r_ay, n_ay;
    logic [COORD_W-1:0]        r_now, n_now;
    logic signed [COORD_W-1:0] r_accx, n_accx, r_accy, n_accy;
    logic                      r_was_query, n_was_query;
    logic [MAG_W-1:0]          r_mx, n_mx, r_my, n_my;
    logic                      r_nx, n_nx, r_ny, n_ny;
    logic [SQ_W-1:0]           r_prod, n_prod;
    logic [SQ_W-1:0]           r_sqv, n_sqv;
    logic [ROOT_W+2:0]         r_rem, n_rem;
    logic [ROOT_W-1:0]         r_root, n_root;
    logic [ROOT_W-1:0]         r_den, n_den;
    logic [ROOT_W-1:0]         r_drem, n_drem;
    logic [WEIGHT_W-1:0]       r_dlow, n_dlow;
    logic [4:0]                r_step, n_step;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    // Table write controls.
    logic                entry_we;
    logic                weight_we;
    logic [IW-1:0]       weight_addr;
    logic [WEIGHT_W-1:0] weight_data;

    logic [IW-1:0]       ri;
    logic [IW-1:0]       widx;
    logic                in_fire;
    logic [COORD_W-1:0]  mul_a, mul_b;
    logic [SQ_W-1:0]     mul_p;

    // Per-entry lookup and direction.
    logic [COORD_W-1:0]        age;
    logic                      alive;
    logic                      use_anchor;
    logic signed [COORD_W:0]   dx, dy;
    logic [COORD_W:0]          ax_mag, ay_mag;
    logic [ROOT_W+2:0]         sq_sh, sq_trial;
    logic [ROOT_W:0]           dv_sh;
    logic [WEIGHT_W:0]         nw;

    assign ri      = r_i[IW-1:0];
    assign widx    = IW'(i_in.data.entry_index);
    assign in_fire = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQX: begin
                mul_a = COORD_W'(r_mx);
                mul_b = COORD_W'(r_mx);
            end
            ST_SQY: begin
                mul_a = COORD_W'(r_my);
                mul_b = COORD_W'(r_my);
            end
            ST_MULX: begin
                mul_a = COORD_W'(r_w_mem[ri]);
                mul_b = COORD_W'(r_mx);
            end
            ST_MULY: begin
                mul_a = COORD_W'(r_w_mem[ri]);
                mul_b = COORD_W'(r_my);
            end
            ST_DECAY: begin
                mul_a = COORD_W'(r_w_mem[ri]);
                mul_b = COORD_W'(r_dec_mem[ri]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        age        = r_now - r_birth_mem[ri];
        alive      = $signed(age) < $signed(r_life_mem[ri]);
        use_anchor = alive && (r_w_mem[ri] > WEIGHT_MIN) && r_has_mem[ri];
        dx         = $signed({r_tx_mem[ri][COORD_W-1], r_tx_mem[ri]}) -
                     $signed({r_ax[COORD_W-1], r_ax});
        dy         = $signed({r_ty_mem[ri][COORD_W-1], r_ty_mem[ri]}) -
                     $signed({r_ay[COORD_W-1], r_ay});
        ax_mag     = dx[COORD_W] ? (~dx + 1'b1) : dx;
        ay_mag     = dy[COORD_W] ? (~dy + 1'b1) : dy;
        sq_sh      = {r_rem[ROOT_W:0], r_sqv[SQ_W-1 -: 2]};
        sq_trial   = {1'b0, r_root, 2'b01};
        dv_sh      = {r_drem, r_dlow[WEIGHT_W-1]};
        nw         = mul_p[WEIGHT_W+16:16];
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_now       = r_now;
        n_accx      = r_accx;
        n_accy      = r_accy;
        n_was_query = r_was_query;
        n_mx        = r_mx;
        n_my        = r_my;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_prod      = r_prod;
        n_sqv       = r_sqv;
        n_rem       = r_rem;
        n_root      = r_root;
        n_den       = r_den;
        n_drem      = r_drem;
        n_dlow      = r_dlow;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        entry_we    = 1'b0;
        weight_we   = 1'b0;
        weight_addr = ri;
        weight_data = r_w_mem[ri];

        if (i_cfg.valid) begin
            n_active = i_cfg.data.active_count;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_accx = '0;
                    n_accy = '0;
                    n_i    = '0;
                    if (i_in.data.req_type == REQ_WRITE) begin
                        n_was_query = 1'b0;
                        if (32'(i_in.data.entry_index) < MAX_ANCHORS) begin
                            entry_we    = 1'b1;
                            weight_we   = 1'b1;
                            weight_addr = widx;
                            weight_data = i_in.data.start_weight;
                        end
                        n_state = ST_DONE;
                    end else begin
                        n_was_query = 1'b1;
                        n_ax        = i_in.data.agent_x;
                        n_ay        = i_in.data.agent_y;
                        n_now       = i_in.data.now_iter;
                        if (32'(r_active) > MAX_ANCHORS) begin
                            n_cnt = CW'(MAX_ANCHORS);
                        end else begin
                            n_cnt = CW'(r_active);
                        end
                        n_state = (r_active == '0) ? ST_DONE : ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_nx = dx[COORD_W];
                n_ny = dy[COORD_W];
                // Halve both magnitudes when either would not fit in 31 bits.
                if ((ax_mag[COORD_W:MAG_W] != '0) || (ay_mag[COORD_W:MAG_W] != '0)) begin
                    n_mx = ax_mag[MAG_W:1];
                    n_my = ay_mag[MAG_W:1];
                end else begin
                    n_mx = ax_mag[MAG_W-1:0];
                    n_my = ay_mag[MAG_W-1:0];
                end
                if (use_anchor && ((dx != '0) || (dy != '0))) begin
                    n_state = ST_SQX;
                end else begin
                    n_state = ST_DECAY;
                end
            end
            ST_SQX: begin
                n_prod  = mul_p;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_sqv   = r_prod;
                n_prod  = mul_p;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_sqv   = r_sqv + r_prod;
                n_rem   = '0;
                n_root  = '0;
                n_step  = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                // One root bit per cycle, restoring digit recurrence.
                n_sqv = {r_sqv[SQ_W-3:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    n_rem  = sq_sh - sq_trial;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = sq_sh;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_step = r_step + 5'd1;
                if (r_step == 5'(SQRT_STEPS - 1)) begin
                    n_state = ST_MULX;
                end
            end
            ST_MULX, ST_MULY: begin
                if (r_state == ST_MULX) begin
                    n_den = (r_root == '0) ? ROOT_W'(1) : r_root;
                end
                // The quotient is at most the weight, so the upper part is below the divisor.
                n_drem  = ROOT_W'(mul_p[WEIGHT_W+MAG_W-1:WEIGHT_W]);
                n_dlow  = mul_p[WEIGHT_W-1:0];
                n_step  = '0;
                n_state = (r_state == ST_MULX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY: begin
                if (dv_sh >= {1'b0, r_den}) begin
                    n_drem = ROOT_W'(dv_sh - {1'b0, r_den});
                    n_dlow = {r_dlow[WEIGHT_W-2:0], 1'b1};
                end else begin
                    n_drem = dv_sh[ROOT_W-1:0];
                    n_dlow = {r_dlow[WEIGHT_W-2:0], 1'b0};
                end
                n_step = r_step + 5'd1;
                if (r_step == 5'(DIV_STEPS - 1)) begin
                    if (r_state == ST_DIVX) begin
                        n_accx  = sat_add(r_accx, r_nx, n_dlow);
                        n_state = ST_MULY;
                    end else begin
                        n_accy  = sat_add(r_accy, r_ny, n_dlow);
                        n_state = ST_DECAY;
                    end
                end
            end
            ST_DECAY: begin
                weight_we   = 1'b1;
                weight_data = nw[WEIGHT_W] ? WEIGHT_MAX : nw[WEIGHT_W-1:0];
                n_i         = r_i + CW'(1);
                n_state     = (r_i + CW'(1) == r_cnt) ? ST_DONE : ST_LOOK;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.net_x     = r_accx;
                    n_out.net_y     = r_accy;
                    n_out.was_query = r_was_query;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_i         <= n_i;
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_now       <= n_now;
        r_accx      <= n_accx;
        r_accy      <= n_accy;
        r_was_query <= n_was_query;
        r_mx        <= n_mx;
        r_my        <= n_my;
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_prod      <= n_prod;
        r_sqv       <= n_sqv;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_den       <= n_den;
        r_drem      <= n_drem;
        r_dlow      <= n_dlow;
        r_step      <= n_step;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (entry_we) begin
            r_tx_mem[widx]    <= i_in.data.target_x;
            r_ty_mem[widx]    <= i_in.data.target_y;
            r_dec_mem[widx]   <= i_in.data.decay_factor;
            r_birth_mem[widx] <= i_in.data.birth_iter;
            r_life_mem[widx]  <= i_in.data.lifetime;
        end
        if (weight_we) begin
            r_w_mem[weight_addr] <= weight_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ANCHORS; k++) begin
                r_has_mem[k] <= 1'b0;
            end
        end else if (entry_we) begin
            r_has_mem[widx] <= i_in.data.target_present;
        end
    end

endmodule
